FILE: design/srt_pkg.sv
// shared opcode and status codes for the sorted rectangle table
package srt_pkg;

   localparam int ID_BITS     = 16;
   localparam int OPCODE_BITS = 3;
   localparam int STATUS_BITS = 3;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_INSERT = 3'd0,
      OP_REMOVE = 3'd1,
      OP_FIRST  = 3'd2,
      OP_LAST   = 3'd3,
      OP_NEXT   = 3'd4,
      OP_CLEAR  = 3'd5
   } opcode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 3'd0,
      ST_OVERLAP   = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_NO_ITEM   = 3'd4
   } status_type;

endpackage

FILE: design/sorted_rectangle_table.sv
// Table of up to TABLE_DEPTH display rectangles, kept in ascending (y, x) order in one
// single-port-read, single-port-write memory with a registered read. One request is worked
// at a time and gives exactly one response. An insert reads every stored entry once for the
// overlap check and the insertion point, then moves the entries behind the insertion point
// up by one, one entry per cycle. A remove does the same with a search by id and a move down.
// First, last and next read one entry from the memory when they return one and skip the
// read when they report no item; clear and unused opcodes go straight to the response. A new
// request is taken while the previous response still waits on the output register. No
// clearing pass follows reset.
module sorted_rectangle_table #(
   parameter int TABLE_DEPTH = 64,
   parameter int COORD_BITS  = 10
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // item_id, pos_x, pos_y, len_x, len_y, zero pad
   input  logic [((srt_pkg::ID_BITS + 4*COORD_BITS + 7)/8)*8-1:0] req_tdata,
   // opcode
   input  logic [srt_pkg::OPCODE_BITS-1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // result_id, entry_count, zero pad
   output logic [((srt_pkg::ID_BITS + $clog2(TABLE_DEPTH+1) + 7)/8)*8-1:0] rsp_tdata,
   // status
   output logic [srt_pkg::STATUS_BITS-1:0] rsp_tuser
);

   localparam int AW     = $clog2(TABLE_DEPTH);
   localparam int CW     = $clog2(TABLE_DEPTH + 1);
   localparam int EW     = srt_pkg::ID_BITS + 4*COORD_BITS;
   localparam int OUT_DW = ((srt_pkg::ID_BITS + CW + 7)/8)*8;
   localparam int X_LSB  = srt_pkg::ID_BITS;
   localparam int Y_LSB  = X_LSB + COORD_BITS;
   localparam int W_LSB  = Y_LSB + COORD_BITS;
   localparam int H_LSB  = W_LSB + COORD_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT_UP,
      S_SHIFT_DOWN,
      S_LOOK,
      S_FINISH
   } state_type;

   state_type              state_ff, state_in;
   srt_pkg::opcode_type    op_ff, op_in;
   logic [EW-1:0]          new_ff, new_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          walk_ff, walk_in;
   logic [CW-1:0]          scan_ff, scan_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic [CW-1:0]          rd_idx_ff, rd_idx_in;
   logic                   hit_ff, hit_in;
   logic                   pos_found_ff, pos_found_in;
   logic [CW-1:0]          pos_ff, pos_in;
   srt_pkg::status_type    res_status_ff, res_status_in;
   logic [srt_pkg::ID_BITS-1:0] res_id_ff, res_id_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   srt_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic [srt_pkg::ID_BITS-1:0] rsp_id_ff, rsp_id_in;
   logic [CW-1:0]          rsp_count_ff, rsp_count_in;

   logic [EW-1:0]          mem [TABLE_DEPTH];
   logic [EW-1:0]          rd_data_ff;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [EW-1:0]          wr_data;

   logic [CW-1:0]          last_idx;
   logic [CW-1:0]          shift_src;
   logic [CW-1:0]          pos_next;
   srt_pkg::opcode_type    req_op;

   // closed interval test, lo + len without wrap
   function automatic logic in_span(input logic [COORD_BITS:0]   v,
                                    input logic [COORD_BITS-1:0] lo,
                                    input logic [COORD_BITS-1:0] len);
      logic [COORD_BITS:0] hi;
      hi = {1'b0, lo} + {1'b0, len};
      return (v >= {1'b0, lo}) && (v <= hi);
   endfunction

   // some corner of b lies inside a
   function automatic logic corner_in(input logic [EW-1:0] a, input logic [EW-1:0] b);
      logic [COORD_BITS-1:0] ax, ay, aw, ah, bx, by, bw, bh;
      logic xl, xr, yt, yb;
      ax = a[X_LSB +: COORD_BITS];
      ay = a[Y_LSB +: COORD_BITS];
      aw = a[W_LSB +: COORD_BITS];
      ah = a[H_LSB +: COORD_BITS];
      bx = b[X_LSB +: COORD_BITS];
      by = b[Y_LSB +: COORD_BITS];
      bw = b[W_LSB +: COORD_BITS];
      bh = b[H_LSB +: COORD_BITS];
      xl = in_span({1'b0, bx}, ax, aw);
      xr = in_span({1'b0, bx} + {1'b0, bw}, ax, aw);
      yt = in_span({1'b0, by}, ay, ah);
      yb = in_span({1'b0, by} + {1'b0, bh}, ay, ah);
      return (xl || xr) && (yt || yb);
   endfunction

   // n comes after e in (y, x) order
   function automatic logic follows(input logic [EW-1:0] e, input logic [EW-1:0] n);
      logic [COORD_BITS-1:0] ex, ey, nx, ny;
      ex = e[X_LSB +: COORD_BITS];
      ey = e[Y_LSB +: COORD_BITS];
      nx = n[X_LSB +: COORD_BITS];
      ny = n[Y_LSB +: COORD_BITS];
      return (ny > ey) || ((ny == ey) && (nx > ex));
   endfunction

   assign last_idx  = count_ff - CW'(1);
   assign shift_src = scan_ff - CW'(1);
   assign pos_next  = pos_ff + CW'(1);
   assign req_op    = srt_pkg::opcode_type'(req_tuser);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = OUT_DW'({rsp_count_ff, rsp_id_ff});

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      new_in        = new_ff;
      count_in      = count_ff;
      walk_in       = walk_ff;
      scan_in       = scan_ff;
      rd_valid_in   = 1'b0;
      rd_idx_in     = rd_idx_ff;
      hit_in        = hit_ff;
      pos_found_in  = pos_found_ff;
      pos_in        = pos_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_count_in  = rsp_count_ff;
      rd_en         = 1'b0;
      rd_addr       = scan_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = rd_idx_ff[AW-1:0];
      wr_data       = rd_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in         = req_op;
               new_in        = req_tdata[EW-1:0];
               res_id_in     = '0;
               res_status_in = srt_pkg::ST_OK;
               hit_in        = 1'b0;
               pos_found_in  = 1'b0;
               pos_in        = count_ff;
               scan_in       = '0;
               state_in      = S_FINISH;
               case (req_op)
                  srt_pkg::OP_INSERT, srt_pkg::OP_REMOVE: begin
                     state_in = S_SCAN;
                  end
                  srt_pkg::OP_FIRST: begin
                     if (count_ff == '0) begin
                        res_status_in = srt_pkg::ST_NO_ITEM;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        walk_in  = CW'(1);
                        state_in = S_LOOK;
                     end
                  end
                  srt_pkg::OP_LAST: begin
                     if (count_ff == '0) begin
                        res_status_in = srt_pkg::ST_NO_ITEM;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = last_idx[AW-1:0];
                        walk_in  = count_ff;
                        state_in = S_LOOK;
                     end
                  end
                  srt_pkg::OP_NEXT: begin
                     if (count_ff == '0 || walk_ff == '0) begin
                        res_status_in = srt_pkg::ST_NO_ITEM;
                     end else if (walk_ff < count_ff) begin
                        rd_en    = 1'b1;
                        rd_addr  = walk_ff[AW-1:0];
                        walk_in  = walk_ff + CW'(1);
                        state_in = S_LOOK;
                     end else begin
                        walk_in       = '0;
                        res_status_in = srt_pkg::ST_NO_ITEM;
                     end
                  end
                  srt_pkg::OP_CLEAR: begin
                     count_in = '0;
                     walk_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (scan_ff < count_ff) begin
               rd_en       = 1'b1;
               rd_addr     = scan_ff[AW-1:0];
               rd_valid_in = 1'b1;
               rd_idx_in   = scan_ff;
               scan_in     = scan_ff + CW'(1);
            end
            if (rd_valid_ff) begin
               if (op_ff == srt_pkg::OP_INSERT) begin
                  if (corner_in(rd_data_ff, new_ff) || corner_in(new_ff, rd_data_ff)) begin
                     hit_in = 1'b1;
                  end
                  if (!pos_found_ff && !follows(rd_data_ff, new_ff)) begin
                     pos_found_in = 1'b1;
                     pos_in       = rd_idx_ff;
                  end
               end else begin
                  if (!hit_ff && rd_data_ff[srt_pkg::ID_BITS-1:0] ==
                                 new_ff[srt_pkg::ID_BITS-1:0]) begin
                     hit_in = 1'b1;
                     pos_in = rd_idx_ff;
                  end
               end
            end
            if (scan_ff >= count_ff && !rd_valid_ff) begin
               if (op_ff == srt_pkg::OP_INSERT) begin
                  if (hit_ff) begin
                     res_status_in = srt_pkg::ST_OVERLAP;
                     state_in      = S_FINISH;
                  end else if (count_ff == CW'(TABLE_DEPTH)) begin
                     res_status_in = srt_pkg::ST_FULL;
                     state_in      = S_FINISH;
                  end else begin
                     scan_in  = count_ff;
                     state_in = S_SHIFT_UP;
                  end
               end else begin
                  if (!hit_ff) begin
                     res_status_in = srt_pkg::ST_NOT_FOUND;
                     state_in      = S_FINISH;
                  end else begin
                     scan_in  = pos_next;
                     state_in = S_SHIFT_DOWN;
                  end
               end
            end
         end

         // scan_ff is the slot that the next moved entry lands in
         S_SHIFT_UP: begin
            if (scan_ff > pos_ff) begin
               rd_en       = 1'b1;
               rd_addr     = shift_src[AW-1:0];
               rd_valid_in = 1'b1;
               rd_idx_in   = shift_src;
               scan_in     = shift_src;
            end
            if (rd_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_idx_ff[AW-1:0] + AW'(1);
               wr_data = rd_data_ff;
            end else if (scan_ff == pos_ff) begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff[AW-1:0];
               wr_data  = new_ff;
               count_in = count_ff + CW'(1);
               if (walk_ff != '0 && walk_ff > pos_ff) begin
                  walk_in = walk_ff + CW'(1);
               end
               state_in = S_FINISH;
            end
         end

         S_SHIFT_DOWN: begin
            if (scan_ff < count_ff) begin
               rd_en       = 1'b1;
               rd_addr     = scan_ff[AW-1:0];
               rd_valid_in = 1'b1;
               rd_idx_in   = scan_ff;
               scan_in     = scan_ff + CW'(1);
            end
            if (rd_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_idx_ff[AW-1:0] - AW'(1);
               wr_data = rd_data_ff;
            end else if (scan_ff >= count_ff) begin
               count_in = count_ff - CW'(1);
               if (walk_ff != '0) begin
                  if (walk_ff == pos_next) begin
                     walk_in = '0;
                  end else if (walk_ff > pos_next) begin
                     walk_in = walk_ff - CW'(1);
                  end
               end
               state_in = S_FINISH;
            end
         end

         S_LOOK: begin
            res_id_in = rd_data_ff[srt_pkg::ID_BITS-1:0];
            state_in  = S_FINISH;
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = res_id_ff;
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         walk_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         walk_ff      <= walk_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      new_ff        <= new_in;
      scan_ff       <= scan_in;
      rd_idx_ff     <= rd_idx_in;
      hit_ff        <= hit_in;
      pos_found_ff  <= pos_found_in;
      pos_ff        <= pos_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule
